// ===== design/bal_pkg.sv =====
// Shared types, luma weights and glyph table for the tile-average ASCII core.
package bal_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [6:0] symbol;
        logic       row_end;
    } tile_t;

    // Tile completion handed from the accumulator to the result pipe
    typedef struct packed {
        logic valid;
        logic row_end;
    } tile_tag_t;

    localparam int LUMA_W = 8;
    localparam int WSUM_W = 24;

    // 0.16 weights, they sum to 65536
    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    localparam int N_LIMITS = 9;

    localparam logic [7:0] LUMA_LIMIT [N_LIMITS] = '{
        8'd230, 8'd170, 8'd150, 8'd120, 8'd100, 8'd82, 8'd62, 8'd50, 8'd35
    };

    localparam logic [6:0] GLYPH [N_LIMITS + 1] = '{
        7'd64,  // '@'
        7'd65,  // 'A'
        7'd42,  // '*'
        7'd111, // 'o'
        7'd63,  // '?'
        7'd43,  // '+'
        7'd58,  // ':'
        7'd39,  // quote
        7'd46,  // '.'
        7'd32   // space
    };

    localparam logic [6:0] GLYPH_MIN = 7'd32;
    localparam logic [6:0] GLYPH_MAX = 7'd126;

    // First descending limit that the luma exceeds picks the glyph
    function automatic logic [6:0] pick_glyph(input logic [LUMA_W-1:0] luma);
        logic [6:0] g;
        g = GLYPH[N_LIMITS];
        for (int i = N_LIMITS - 1; i >= 0; i--) begin
            if (luma > LUMA_LIMIT[i]) begin
                g = GLYPH[i];
            end
        end
        return g;
    endfunction

endpackage

// ===== design/bal_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bal_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 80,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bal_accum.sv =====
// Raster position counters and per-tile-column channel accumulation.
module bal_accum import bal_pkg::*; #(
    parameter int IMAGE_WIDTH = 800,
    parameter int TILE_SIZE   = 10,
    parameter int SUM_W       = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pix_t             in_data,
    input  logic             in_valid,
    output logic             in_ready,
    output tile_tag_t        tag,
    output logic [SUM_W-1:0] red_sum,
    output logic [SUM_W-1:0] green_sum,
    output logic [SUM_W-1:0] blue_sum,
    input  logic             res_ready
);

    localparam int TILE_COLS = IMAGE_WIDTH / TILE_SIZE;
    localparam int DEPTH     = (TILE_COLS > 1) ? TILE_COLS : 1;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW        = (TILE_COLS > 0) ? $clog2(TILE_COLS + 1) : 1;
    localparam int CW        = $clog2(IMAGE_WIDTH);
    localparam int KW        = $clog2(TILE_SIZE);
    localparam int MW        = 3 * SUM_W;

    typedef struct packed {
        logic in_tile;
        logic first;
        logic last;
        logic line0;
        logic last_line;
        logic row_end;
    } flags_t;

    logic [CW-1:0] col_reg, col_next;
    logic [KW-1:0] cit_reg, cit_next;
    logic [TW-1:0] tile_reg, tile_next;
    logic [KW-1:0] line_reg, line_next;

    logic          s1_valid_reg, s1_valid_next;
    pix_t          s1_pix_reg;
    flags_t        s1_flags_reg;
    logic [AW-1:0] s1_tile_reg;

    logic [SUM_W-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic             byp_valid_reg;
    logic [MW-1:0]    byp_data_reg;

    flags_t        in_flags;
    logic          in_fire, s1_fire, emit, we;
    logic [AW-1:0] rd_addr;
    logic [MW-1:0] mem_q, rd_word, wr_data;
    logic [SUM_W-1:0] base_r, base_g, base_b;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        in_flags.in_tile   = (tile_reg < TW'(TILE_COLS));
        in_flags.first     = (cit_reg == '0);
        in_flags.last      = (cit_reg == KW'(TILE_SIZE - 1));
        in_flags.line0     = (line_reg == '0);
        in_flags.last_line = (line_reg == KW'(TILE_SIZE - 1));
        in_flags.row_end   = (tile_reg == TW'(TILE_COLS - 1));
    end

    always_comb
    begin
        col_next  = col_reg;
        cit_next  = cit_reg;
        tile_next = tile_reg;
        line_next = line_reg;
        if (in_fire)
        begin
            if (col_reg == CW'(IMAGE_WIDTH - 1))
            begin
                col_next  = '0;
                cit_next  = '0;
                tile_next = '0;
                line_next = in_flags.last_line ? '0 : line_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (in_flags.last)
                begin
                    cit_next  = '0;
                    tile_next = tile_reg + 1'b1;
                end
                else
                begin
                    cit_next = cit_reg + 1'b1;
                end
            end
        end
    end

    assign emit = s1_valid_reg && s1_flags_reg.in_tile && s1_flags_reg.last
                  && s1_flags_reg.last_line;
    assign s1_fire  = s1_valid_reg && (!emit || res_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Partial sums of earlier lines of the tile row live in the RAM; line 0 starts
    // from zero, so the RAM never needs clearing.
    assign rd_word = byp_valid_reg ? byp_data_reg : mem_q;

    always_comb
    begin
        if (!s1_flags_reg.first)
        begin
            base_r = acc_r_reg;
            base_g = acc_g_reg;
            base_b = acc_b_reg;
        end
        else if (s1_flags_reg.line0)
        begin
            base_r = '0;
            base_g = '0;
            base_b = '0;
        end
        else
        begin
            base_r = rd_word[2*SUM_W +: SUM_W];
            base_g = rd_word[SUM_W +: SUM_W];
            base_b = rd_word[0 +: SUM_W];
        end
    end

    assign red_sum   = base_r + SUM_W'(s1_pix_reg.red);
    assign green_sum = base_g + SUM_W'(s1_pix_reg.green);
    assign blue_sum  = base_b + SUM_W'(s1_pix_reg.blue);

    assign tag.valid   = emit;
    assign tag.row_end = s1_flags_reg.row_end;

    assign we      = s1_fire && s1_flags_reg.in_tile && s1_flags_reg.last
                     && !s1_flags_reg.last_line;
    assign wr_data = {red_sum, green_sum, blue_sum};
    assign rd_addr = tile_reg[AW-1:0];

    bal_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_sum_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (s1_tile_reg),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (mem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            cit_reg       <= '0;
            tile_reg      <= '0;
            line_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            cit_reg      <= cit_next;
            tile_reg     <= tile_next;
            line_reg     <= line_next;
            s1_valid_reg <= s1_valid_next;
            // write and read of the same entry in one cycle: forward the new word
            if (in_fire)
            begin
                byp_valid_reg <= we && (s1_tile_reg == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg   <= in_data;
            s1_flags_reg <= in_flags;
            s1_tile_reg  <= rd_addr;
            byp_data_reg <= wr_data;
        end
        if (s1_fire && s1_flags_reg.in_tile)
        begin
            acc_r_reg <= red_sum;
            acc_g_reg <= green_sum;
            acc_b_reg <= blue_sum;
        end
    end

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg == '0) |-> (cit_reg == '0 && tile_reg == '0))
        else $error("tile counters out of step with pixel column");

    a_tile_range: assert property (@(posedge clk) disable iff (!rst_n)
        tile_reg <= TW'(TILE_COLS))
        else $error("tile index ran past the partial tile column");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !res_ready) |=> (s1_valid_reg && $stable(s1_tile_reg)))
        else $error("finished tile dropped while result pipe stalled");

endmodule

// ===== design/bal_result.sv =====
// Average by tile area, luma weighting, glyph pick and output register.
module bal_result import bal_pkg::*; #(
    parameter int TILE_SIZE = 10,
    parameter int SUM_W     = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tile_tag_t        tag,
    input  logic [SUM_W-1:0] red_sum,
    input  logic [SUM_W-1:0] green_sum,
    input  logic [SUM_W-1:0] blue_sum,
    output logic             res_ready,
    output tile_t            out_data,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int AREA    = TILE_SIZE * TILE_SIZE;
    // Reciprocal with SUM_W + 8 fraction bits is exact for every sum below 2**SUM_W
    localparam int SHIFT   = SUM_W + 8;
    localparam int RECIP_W = SHIFT;
    localparam int RECIP   = ((1 << SHIFT) + AREA - 1) / AREA;
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic             en;
    logic             s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic             s2_row_end_reg, s3_row_end_reg, s4_row_end_reg;
    logic [SUM_W-1:0] s2_r_reg, s2_g_reg, s2_b_reg;
    logic [PROD_W-1:0] s3_r_reg, s3_g_reg, s3_b_reg;
    logic [LUMA_W-1:0] s4_luma_reg;
    tile_t            out_reg;

    logic [LUMA_W-1:0] avg_r, avg_g, avg_b;
    logic [WSUM_W-1:0] wsum;

    assign en        = !out_valid_reg || out_ready;
    assign res_ready = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign avg_r = s3_r_reg[SHIFT +: LUMA_W];
    assign avg_g = s3_g_reg[SHIFT +: LUMA_W];
    assign avg_b = s3_b_reg[SHIFT +: LUMA_W];

    assign wsum = WSUM_W'(LUMA_WR) * WSUM_W'(avg_r)
                + WSUM_W'(LUMA_WG) * WSUM_W'(avg_g)
                + WSUM_W'(LUMA_WB) * WSUM_W'(avg_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= tag.valid;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_row_end_reg  <= tag.row_end;
            s2_r_reg        <= red_sum;
            s2_g_reg        <= green_sum;
            s2_b_reg        <= blue_sum;
            s3_row_end_reg  <= s2_row_end_reg;
            s3_r_reg        <= PROD_W'(s2_r_reg) * PROD_W'(RECIP_V);
            s3_g_reg        <= PROD_W'(s2_g_reg) * PROD_W'(RECIP_V);
            s3_b_reg        <= PROD_W'(s2_b_reg) * PROD_W'(RECIP_V);
            s4_row_end_reg  <= s3_row_end_reg;
            s4_luma_reg     <= wsum[WSUM_W-1 -: LUMA_W];
            out_reg.symbol  <= pick_glyph(s4_luma_reg);
            out_reg.row_end <= s4_row_end_reg;
        end
    end

    a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.symbol >= GLYPH_MIN && out_reg.symbol <= GLYPH_MAX))
        else $error("glyph code outside printable range");

endmodule

// ===== design/block_average_ascii_luma_core.sv =====
// A tile's result passes from its bottom-right pixel transfer through s1, s2, s3, s4 and the output register.
// Throughput: one pixel per cycle while the result pipe is not stalled; at most one tile result per TILE_SIZE pixels.
// The pace is set by the per-column sum RAM, read when a pixel transfers and
// written once that pixel leaves the s1 stage, with a forward path for back-to-back access.
// Reset clears position counters and pipe valids; the sum RAM is not cleared,
// since the first line of each tile row starts its sums from zero.
module block_average_ascii_luma_core import bal_pkg::*; #(
    parameter int IMAGE_WIDTH = 800,
    parameter int TILE_SIZE   = 10
) (
    input  logic  clk,
    input  logic  rst_n,
    input  pix_t  in_data,
    input  logic  in_valid,
    output logic  in_ready,
    output tile_t out_data,
    output logic  out_valid,
    input  logic  out_ready
);

    localparam int SUM_W = $clog2(TILE_SIZE * TILE_SIZE * 255 + 1);

    tile_tag_t        tag;
    logic [SUM_W-1:0] red_sum, green_sum, blue_sum;
    logic             res_ready;

    bal_accum #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .TILE_SIZE   (TILE_SIZE),
        .SUM_W       (SUM_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tag       (tag),
        .red_sum   (red_sum),
        .green_sum (green_sum),
        .blue_sum  (blue_sum),
        .res_ready (res_ready)
    );

    bal_result #(
        .TILE_SIZE (TILE_SIZE),
        .SUM_W     (SUM_W)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .red_sum   (red_sum),
        .green_sum (green_sum),
        .blue_sum  (blue_sum),
        .res_ready (res_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
